/* rtl/core/tcce_pkg.sv */
`default_nettype none

package tcce_pkg;

    // Request codes carried by req_type. Codes 6 and 7 have no meaning.
    typedef enum logic [2:0] {
        REQ_CHAR        = 3'd0,
        REQ_SCROLL_UP   = 3'd1,
        REQ_SCROLL_DOWN = 3'd2,
        REQ_LEFT        = 3'd3,
        REQ_RIGHT       = 3'd4,
        REQ_CLEAR       = 3'd5
    } t_req;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN     = 2'd0,
        CFG_SPAN       = 2'd1,
        CFG_CHAR_ATTR  = 2'd2,
        CFG_BLANK_ATTR = 2'd3
    } t_cfg_idx;

    localparam int unsigned CELL_W = 16;
    localparam int unsigned BYTE_W = 8;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [BYTE_W-1:0] t_byte;

    // Control characters with a meaning of their own.
    localparam t_byte CH_LF = 8'h0A;
    localparam t_byte CH_CR = 8'h0D;
    localparam t_byte CH_BS = 8'h08;

    // Register values after reset.
    localparam t_cell RST_ORIGIN     = 16'd0;
    localparam t_cell RST_SPAN       = 16'd16000;
    localparam t_byte RST_CHAR_ATTR  = 8'd7;
    localparam t_byte RST_BLANK_ATTR = 8'd7;

endpackage

`default_nettype wire

/* rtl/core/tcce_in_if.sv */
`default_nettype none

interface tcce_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

`default_nettype wire

/* rtl/core/tcce_out_if.sv */
`default_nettype none

interface tcce_out_if;
    logic        valid;
    logic        ready;
    logic        write_char;
    logic        write_attr;
    logic [15:0] cell_index;
    logic [7:0]  char_byte;
    logic [7:0]  attr_byte;
    logic [15:0] cursor_pos;
    logic [15:0] view_start;

    modport source (
        output valid, output write_char, output write_attr, output cell_index,
        output char_byte, output attr_byte, output cursor_pos, output view_start,
        input  ready
    );
    modport sink (
        input  valid, input write_char, input write_attr, input cell_index,
        input  char_byte, input attr_byte, input cursor_pos, input view_start,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/tcce_cfg_if.sv */
`default_nettype none

interface tcce_cfg_if
    import tcce_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/tcce_row_mod.sv */
`default_nettype none

// Remainder of a 16-bit cell number by the row width. The value is split
// into two bytes; each byte's share of the remainder comes from a constant
// table, and their sum is below twice the row width, so one conditional
// subtract finishes the job.
module tcce_row_mod
    import tcce_pkg::*;
#(
    parameter int unsigned ROW_CELLS = 80
) (
    input  wire t_cell       i_value,
    output logic [BYTE_W-1:0] o_rem
);

    localparam logic [BYTE_W:0] ROW_W9 = (BYTE_W+1)'(ROW_CELLS);

    logic [BYTE_W-1:0] w_hi_tab [256];
    logic [BYTE_W-1:0] w_lo_tab [256];
    logic [BYTE_W:0]   w_sum;
    logic [BYTE_W:0]   w_red;

    for (genvar g = 0; g < 256; g++) begin : g_tab
        assign w_hi_tab[g] = BYTE_W'((g * 256) % ROW_CELLS);
        assign w_lo_tab[g] = BYTE_W'(g % ROW_CELLS);
    end

    always_comb begin
        w_sum = {1'b0, w_hi_tab[i_value[15:8]]} + {1'b0, w_lo_tab[i_value[7:0]]};
        if (w_sum >= ROW_W9) begin
            w_red = w_sum - ROW_W9;
        end else begin
            w_red = w_sum;
        end
        o_rem = w_red[BYTE_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/core/text_console_cursor_engine_core.sv */
// Pipeline: a word accepted on the input channel passes the input register and then
// the result register (two register stages) before its result shows on the output.
// Throughput: one word per cycle unless the output stalls; the cursor and view start
// update in the same cycle a word leaves the input register, so the following word
// sees them at once. Reset (synchronous, active low) empties both stages, sets cursor
// and view start to zero and loads the configuration registers with their defaults.
`default_nettype none

module text_console_cursor_engine_core
    import tcce_pkg::*;
#(
    parameter int unsigned ROW_CELLS = 80
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcce_in_if.sink     i_in,
    tcce_out_if.source  o_out,
    tcce_cfg_if.sink    i_cfg
);

    localparam t_cell ROW_W = CELL_W'(ROW_CELLS);

    // Configuration registers
    t_cell r_origin;
    t_cell r_span;
    t_byte r_char_attr;
    t_byte r_blank_attr;

    // Input stage
    logic       r_in_vld;
    logic [2:0] r_req;
    t_byte      r_chr;

    // Console state
    t_cell r_cursor;
    t_cell r_view;
    t_cell n_cursor;
    t_cell n_view;

    // Result stage
    logic  r_out_vld;
    logic  r_wc;
    logic  r_wa;
    t_cell r_cell;
    t_byte r_cb;
    t_byte r_ab;

    logic  n_wc;
    logic  n_wa;
    t_cell n_cell;
    t_byte n_cb;
    t_byte n_ab;

    logic  w_out_free;
    logic  w_adv;
    t_cell w_next_row;
    t_cell w_mod_arg;
    logic [BYTE_W-1:0] w_rem;
    t_cell w_row_start;

    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_adv      = r_in_vld && w_out_free;
    assign i_in.ready = !r_in_vld || w_out_free;
    assign i_cfg.ready = 1'b1;

    // Newline aligns to rows counted from the origin, clear to the absolute grid.
    assign w_next_row = r_cursor + ROW_W;
    assign w_mod_arg  = (t_req'(r_req) == REQ_CLEAR) ? w_next_row : (w_next_row - r_origin);
    assign w_row_start = w_next_row - CELL_W'(w_rem);

    tcce_row_mod #(
        .ROW_CELLS (ROW_CELLS)
    ) u_row_mod (
        .i_value (w_mod_arg),
        .o_rem   (w_rem)
    );

    always_comb begin
        n_cursor = r_cursor;
        n_view   = r_view;
        n_wc     = 1'b0;
        n_wa     = 1'b0;
        n_cell   = '0;
        n_cb     = '0;
        n_ab     = '0;
        unique case (t_req'(r_req))
            REQ_CHAR: begin
                if (r_chr == CH_LF || r_chr == CH_CR) begin
                    n_cursor = w_row_start;
                end else if (r_chr == CH_BS) begin
                    n_cursor = r_cursor - 16'd1;
                    n_wa     = 1'b1;
                    n_cell   = r_cursor - 16'd1;
                    n_ab     = r_blank_attr;
                end else begin
                    n_cursor = r_cursor + 16'd1;
                    n_wc     = 1'b1;
                    n_wa     = 1'b1;
                    n_cell   = r_cursor;
                    n_cb     = r_chr;
                    n_ab     = r_char_attr;
                end
            end
            REQ_SCROLL_UP: begin
                if (r_view > r_origin) begin
                    n_view = r_view - ROW_W;
                end
            end
            REQ_SCROLL_DOWN: begin
                if (r_view < (r_origin + r_span)) begin
                    n_view = r_view + ROW_W;
                end
            end
            REQ_LEFT: begin
                n_cursor = r_cursor - 16'd1;
            end
            REQ_RIGHT: begin
                n_cursor = r_cursor + 16'd1;
            end
            REQ_CLEAR: begin
                n_cursor = w_row_start;
                n_view   = w_row_start;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin     <= RST_ORIGIN;
            r_span       <= RST_SPAN;
            r_char_attr  <= RST_CHAR_ATTR;
            r_blank_attr <= RST_BLANK_ATTR;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ORIGIN:     r_origin     <= i_cfg.data;
                CFG_SPAN:       r_span       <= i_cfg.data;
                CFG_CHAR_ATTR:  r_char_attr  <= i_cfg.data[BYTE_W-1:0];
                CFG_BLANK_ATTR: r_blank_attr <= i_cfg.data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_cursor  <= '0;
            r_view    <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_cursor  <= n_cursor;
                r_view    <= n_view;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req <= i_in.req_type;
            r_chr <= i_in.char_code;
        end
        if (w_adv) begin
            r_wc   <= n_wc;
            r_wa   <= n_wa;
            r_cell <= n_cell;
            r_cb   <= n_cb;
            r_ab   <= n_ab;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.write_char = r_wc;
    assign o_out.write_attr = r_wa;
    assign o_out.cell_index = r_cell;
    assign o_out.char_byte  = r_cb;
    assign o_out.attr_byte  = r_ab;
    assign o_out.cursor_pos = r_cursor;
    assign o_out.view_start = r_view;

    // A character byte is never written without its attribute byte.
    a_char_with_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_wc |-> r_wa)
        else $error("character write without attribute write");

    // The remainder unit stays below the row width.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> (32'(w_rem) < ROW_CELLS))
        else $error("row remainder out of range");

    // Clear leaves the view on the cursor's row start.
    a_clear_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (t_req'(r_req) == REQ_CLEAR) |=> (r_view == r_cursor))
        else $error("view does not follow cursor after clear");

    // Stepping right moves the cursor by exactly one cell.
    a_right_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (t_req'(r_req) == REQ_RIGHT) |=> (r_cursor == t_cell'($past(r_cursor) + 16'd1)))
        else $error("cursor step right is wrong");

    // The state only moves when a word leaves the input stage.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_cursor) && $stable(r_view))
        else $error("cursor or view changed without a word");

endmodule

`default_nettype wire

/* dv/tb_text_console_cursor_engine_core.sv */
`default_nettype none

import tcce_pkg::*;

// One result word of the console engine.
typedef struct packed {
    logic  write_char;
    logic  write_attr;
    t_cell cell_index;
    t_byte char_byte;
    t_byte attr_byte;
    t_cell cursor_pos;
    t_cell view_start;
} t_cell_update;

class console_scoreboard #(int unsigned ROW = 80);
    t_cell        origin, span, cursor, view;
    t_byte        char_attr, blank_attr;
    t_cell_update pending_updates[$];
    int unsigned  errors, checked;

    function void reset();
        origin     = RST_ORIGIN;
        span       = RST_SPAN;
        char_attr  = RST_CHAR_ATTR;
        blank_attr = RST_BLANK_ATTR;
        cursor     = '0;
        view       = '0;
        pending_updates.delete();
    endfunction

    function void write_reg(t_cfg_idx idx, t_cell val);
        case (idx)
            CFG_ORIGIN:     origin = val;
            CFG_SPAN:       span = val;
            CFG_CHAR_ATTR:  char_attr = val[7:0];
            CFG_BLANK_ATTR: blank_attr = val[7:0];
            default: ;
        endcase
    endfunction

    // Advances the cursor and view for one accepted word and queues the update it causes.
    function void note_word(logic [2:0] req, t_byte ch);
        t_cell_update upd;
        t_cell        step, diff, lim;
        upd = '0;
        case (req)
            REQ_CHAR: begin
                if (ch == CH_LF || ch == CH_CR) begin
                    // New line is aligned to the row grid relative to the console origin.
                    step   = cursor + t_cell'(ROW);
                    diff   = step - origin;
                    cursor = step - t_cell'(diff % ROW);
                end else if (ch == CH_BS) begin
                    cursor         = cursor - 1'b1;
                    upd.write_attr = 1'b1;
                    upd.cell_index = cursor;
                    upd.attr_byte  = blank_attr;
                end else begin
                    upd.write_char = 1'b1;
                    upd.write_attr = 1'b1;
                    upd.cell_index = cursor;
                    upd.char_byte  = ch;
                    upd.attr_byte  = char_attr;
                    cursor         = cursor + 1'b1;
                end
            end
            REQ_SCROLL_UP: begin
                if (view > origin) view = view - t_cell'(ROW);
            end
            REQ_SCROLL_DOWN: begin
                lim = origin + span;
                if (view < lim) view = view + t_cell'(ROW);
            end
            REQ_LEFT:  cursor = cursor - 1'b1;
            REQ_RIGHT: cursor = cursor + 1'b1;
            REQ_CLEAR: begin
                // Clear uses the absolute row grid, not the origin-relative one.
                step   = cursor + t_cell'(ROW);
                cursor = step - t_cell'(step % ROW);
                view   = cursor;
            end
            default: ;
        endcase
        upd.cursor_pos = cursor;
        upd.view_start = view;
        pending_updates.push_back(upd);
    endfunction

    function void compare_field(string fname, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            errors++;
        end
    endfunction

    function void check_word(t_cell_update got);
        t_cell_update want;
        if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        want = pending_updates.pop_front();
        checked++;
        compare_field("write_char", 16'(want.write_char), 16'(got.write_char));
        compare_field("write_attr", 16'(want.write_attr), 16'(got.write_attr));
        compare_field("cell_index", want.cell_index, got.cell_index);
        compare_field("char_byte", 16'(want.char_byte), 16'(got.char_byte));
        compare_field("attr_byte", 16'(want.attr_byte), 16'(got.attr_byte));
        compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
        compare_field("view_start", want.view_start, got.view_start);
    endfunction

    function int unsigned pending();
        return pending_updates.size();
    endfunction
endclass

module tb_text_console_cursor_engine_core;

    localparam int unsigned ROW_CELLS   = 80;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 100000;

    // Request codes with no meaning; they must leave the cursor and view unchanged.
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;

    tcce_in_if  in_ch ();
    tcce_out_if out_ch ();
    tcce_cfg_if cfg_ch ();

    text_console_cursor_engine_core #(
        .ROW_CELLS(ROW_CELLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    console_scoreboard #(ROW_CELLS) sb;

    int unsigned src_idle, snk_idle;
    int unsigned stall_reqs, stall_seen, stall_left;
    int unsigned n_sent, n_cfg, n_settings, cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_text_console_cursor_engine_core failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus asks for one.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_seen != stall_reqs) begin
                stall_seen = stall_reqs;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Everything is sampled at the clock edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(t_cfg_idx'(cfg_ch.index), cfg_ch.data);
                n_cfg++;
            end
            if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.req_type, in_ch.char_code);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_word('{out_ch.write_char, out_ch.write_attr, out_ch.cell_index,
                                out_ch.char_byte, out_ch.attr_byte, out_ch.cursor_pos,
                                out_ch.view_start});
            end
        end
    end

    // Valid stays high after a handshake so back-to-back words need no second assignment.
    task automatic send_word(logic [2:0] req, t_byte ch);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.char_code <= ch;
        do @(posedge i_clk); while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic put_reg(t_cfg_idx idx, t_cell val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic set_console(t_cell org, t_cell spn, t_byte ca, t_byte ba);
        put_reg(CFG_ORIGIN, org);
        put_reg(CFG_SPAN, spn);
        put_reg(CFG_CHAR_ATTR, {8'h00, ca});
        put_reg(CFG_BLANK_ATTR, {8'h00, ba});
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly text with line breaks; bursts of scrolls reach the view limits.
    task automatic random_words(int unsigned n);
        int unsigned done_n, len, pick;
        logic [2:0]  req;
        done_n = 0;
        while (done_n < n) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                req = $urandom_range(1) ? REQ_SCROLL_UP : REQ_SCROLL_DOWN;
                len = $urandom_range(20, 1);
                repeat (len) send_word(req, t_byte'($urandom_range(255)));
                done_n += len;
            end else if (pick < 22) begin
                req = $urandom_range(1) ? REQ_LEFT : REQ_RIGHT;
                len = $urandom_range(6, 1);
                repeat (len) send_word(req, t_byte'($urandom_range(255)));
                done_n += len;
            end else begin
                if (pick < 27) begin
                    send_word(REQ_CLEAR, t_byte'($urandom_range(255)));
                end else if (pick < 30) begin
                    send_word($urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6,
                              t_byte'($urandom_range(255)));
                end else if (pick < 40) begin
                    case ($urandom_range(2))
                        0:       send_word(REQ_CHAR, CH_LF);
                        1:       send_word(REQ_CHAR, CH_CR);
                        default: send_word(REQ_CHAR, CH_BS);
                    endcase
                end else begin
                    send_word(REQ_CHAR, t_byte'($urandom_range(255)));
                end
                done_n++;
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.req_type  <= REQ_CHAR;
        in_ch.char_code <= 8'h00;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_ORIGIN;
        cfg_ch.data     <= 16'h0000;
        src_idle = 23;
        snk_idle = 59;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings: printable bytes, backspace across zero,
        // cursor wrap both ways, scroll at the origin, clear and the unused codes.
        send_word(REQ_CHAR, 8'h41);
        send_word(REQ_CHAR, 8'h00);
        send_word(REQ_CHAR, CH_BS);
        send_word(REQ_CHAR, CH_BS);
        send_word(REQ_CHAR, CH_BS);
        send_word(REQ_CHAR, 8'hFF);
        send_word(REQ_LEFT, 8'h00);
        send_word(REQ_CHAR, CH_LF);
        send_word(REQ_LEFT, 8'hFF);
        send_word(REQ_RIGHT, 8'h00);
        send_word(REQ_CHAR, CH_LF);
        send_word(REQ_CHAR, 8'h7F);
        send_word(REQ_CHAR, CH_CR);
        send_word(REQ_SCROLL_UP, 8'h00);
        send_word(REQ_SCROLL_DOWN, 8'h00);
        send_word(REQ_SCROLL_DOWN, 8'hFF);
        send_word(REQ_SCROLL_UP, 8'h00);
        send_word(REQ_CLEAR, 8'h00);
        send_word(REQ_UNUSED_6, 8'h55);
        send_word(REQ_UNUSED_7, 8'hAA);
        send_word(REQ_LEFT, 8'h00);
        send_word(REQ_CHAR, CH_LF);
        send_word(REQ_CHAR, 8'h80);
        send_word(REQ_CHAR, 8'h09);

        // Origin near the top so the scroll limit wraps past zero.
        wait_idle();
        set_console(16'hFFF0, 16'hFFFF, 8'hFF, 8'h00);
        random_words(75);
        stall_reqs++;
        random_words(75);

        wait_idle();
        set_console(16'h0000, 16'h0000, 8'h00, 8'hFF);
        src_idle = 59;
        snk_idle = 23;
        random_words(75);
        wait_idle();
        random_words(75);

        wait_idle();
        set_console(t_cell'($urandom_range(16'hFFFF)), t_cell'(ROW_CELLS * $urandom_range(30, 1)),
                    t_byte'($urandom_range(255)), t_byte'($urandom_range(255)));
        src_idle = 0;
        snk_idle = 0;
        random_words(150);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d result words never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Sent %0d words under %0d console settings (%0d register writes),",
                 n_sent, n_settings + 1, n_cfg);
        $display("checked %0d result words, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_text_console_cursor_engine_core passed");
        end else begin
            $display("tb_text_console_cursor_engine_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/tcce_pkg.sv
rtl/core/tcce_in_if.sv
rtl/core/tcce_out_if.sv
rtl/core/tcce_cfg_if.sv
rtl/core/tcce_row_mod.sv
rtl/core/text_console_cursor_engine_core.sv
dv/tb_text_console_cursor_engine_core.sv
